[src/h264sps_pkg.sv]
package h264sps_pkg;

   // sps syntax elements, one-hot
   typedef enum logic [29:0] {
      STEP_HDR       = 30'(1) << 0,
      STEP_PROFILE   = 30'(1) << 1,
      STEP_CONSTR    = 30'(1) << 2,
      STEP_SPSID     = 30'(1) << 3,
      STEP_CHROMA    = 30'(1) << 4,
      STEP_SEPPLANE  = 30'(1) << 5,
      STEP_DEPTHL    = 30'(1) << 6,
      STEP_DEPTHC    = 30'(1) << 7,
      STEP_BYPASS    = 30'(1) << 8,
      STEP_MATRIX    = 30'(1) << 9,
      STEP_LISTFLAG  = 30'(1) << 10,
      STEP_DELTA     = 30'(1) << 11,
      STEP_FRAMENUM  = 30'(1) << 12,
      STEP_POCTYPE   = 30'(1) << 13,
      STEP_POCLSB    = 30'(1) << 14,
      STEP_ALWAYS0   = 30'(1) << 15,
      STEP_NONREF    = 30'(1) << 16,
      STEP_TOPBOT    = 30'(1) << 17,
      STEP_CYCLE     = 30'(1) << 18,
      STEP_REFOFF    = 30'(1) << 19,
      STEP_NUMREF    = 30'(1) << 20,
      STEP_GAPS      = 30'(1) << 21,
      STEP_WIDTH     = 30'(1) << 22,
      STEP_HEIGHT    = 30'(1) << 23,
      STEP_FRAMEONLY = 30'(1) << 24,
      STEP_MBAFF     = 30'(1) << 25,
      STEP_DIRECT    = 30'(1) << 26,
      STEP_CROPFLAG  = 30'(1) << 27,
      STEP_CROP      = 30'(1) << 28,
      STEP_DONE      = 30'(1) << 29
   } step_type;

   typedef enum logic [4:0] {
      SEQ_IDLE   = 5'b00001,
      SEQ_BITS   = 5'b00010,
      SEQ_SIZE_W = 5'b00100,
      SEQ_SIZE_H = 5'b01000,
      SEQ_PUSH   = 5'b10000
   } seq_type;

   localparam logic [5:0] RUN_MAX = 6'd63;
   localparam logic [7:0] SCALE_INIT = 8'd8;
   localparam logic [3:0] LISTS_444 = 4'd12;
   localparam logic [3:0] LISTS_STD = 4'd8;
   localparam logic [3:0] SMALL_LISTS = 4'd6;
   localparam logic [3:0] CROP_COUNT = 4'd4;

   // fixed field length of an element, zero for exp-golomb
   function automatic logic [5:0] step_bits(input step_type s);
      logic [5:0] n;
      case (s)
         STEP_HDR, STEP_PROFILE: n = 6'd8;
         STEP_CONSTR: n = 6'd16;
         STEP_SEPPLANE, STEP_BYPASS, STEP_MATRIX, STEP_LISTFLAG, STEP_ALWAYS0,
         STEP_GAPS, STEP_FRAMEONLY, STEP_MBAFF, STEP_DIRECT, STEP_CROPFLAG: n = 6'd1;
         default: n = 6'd0;
      endcase
      return n;
   endfunction

   function automatic logic high_profile(input logic [7:0] p);
      return p inside {8'd44, 8'd83, 8'd86, 8'd100, 8'd110, 8'd118, 8'd122,
                       8'd128, 8'd244};
   endfunction

endpackage

[src/h264sps_span.sv]
module h264sps_span #(
   parameter int VALUE_BITS = 32,
   parameter int SIZE_BITS = 16
) (
   input  logic [VALUE_BITS-1:0] units,
   input  logic                  mult2,
   input  logic [VALUE_BITS-1:0] off_a,
   input  logic [VALUE_BITS-1:0] off_b,
   output logic [SIZE_BITS-1:0]  size_value,
   output logic                  size_clamped
);
   localparam int AW = 48;
   localparam logic [63:0] CAP = 64'h100_0000_0000;
   localparam logic [AW-1:0] LIMIT = {{(AW-SIZE_BITS){1'b0}}, {SIZE_BITS{1'b1}}};

   function automatic logic [40:0] cap41(input logic [63:0] x);
      return (x > CAP) ? CAP[40:0] : x[40:0];
   endfunction

   logic [AW-1:0] pos;
   logic [AW-1:0] neg;
   logic [AW-1:0] diff;

   always_comb begin
      pos = (AW'(cap41(64'(units))) + AW'(1)) << (mult2 ? 5 : 4);
      neg = (AW'(cap41(64'(off_a))) + AW'(cap41(64'(off_b)))) << 1;
      diff = pos - neg;
      if (neg > pos) begin
         size_value = '0;
         size_clamped = 1'b1;
      end else if (diff > LIMIT) begin
         size_value = '1;
         size_clamped = 1'b1;
      end else begin
         size_value = diff[SIZE_BITS-1:0];
         size_clamped = 1'b0;
      end
   end
endmodule

[src/h264_sps_frame_size_parser.sv]
// Parses one H.264 SPS NAL unit, fed one byte per transaction (header byte first, no
// emulation-prevention removal, req_tlast on the final byte), and returns one result on
// the final byte: cropped width, height, a saturation flag and a flag for data that ended
// before the cropping fields. Each byte is walked one bit per cycle through the syntax
// sequencer, and the next byte is taken in the cycle its last bit is consumed. After the
// final byte, the shared size unit computes the width, then the height, and the result
// register is then loaded, which may stall while an earlier result has not been taken.
module h264_sps_frame_size_parser #(
   parameter int VALUE_BITS = 32,
   parameter int SIZE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // frame_width, frame_height, size_clamped, data_ran_out, zero fill
   output logic [((2*SIZE_BITS+2+7)/8)*8-1:0] rsp_tdata
);
   import h264sps_pkg::*;

   localparam int RSP_W = ((2*SIZE_BITS+2+7)/8)*8;
   localparam logic [VALUE_BITS-1:0] VALUE_TOP = {1'b1, {(VALUE_BITS-1){1'b0}}};

   // sequencer
   seq_type seq_ff, seq_in;
   logic [2:0] bitcnt_ff, bitcnt_in;
   logic [7:0] shift_ff, shift_in;
   logic last_ff, last_in;
   logic [SIZE_BITS-1:0] wres_ff, wres_in, hres_ff, hres_in;
   logic clamp_ff, clamp_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   // syntax walker
   step_type step_ff, step_in;
   logic [5:0] zrun_ff, zrun_in, left_ff, left_in;
   logic [VALUE_BITS-1:0] fval_ff, fval_in, loop_ff, loop_in;
   logic [7:0] profile_ff, profile_in, lscale_ff, lscale_in;
   logic c444_ff, c444_in, fonly_ff, fonly_in;
   logic [3:0] lidx_ff, lidx_in;
   logic [6:0] cidx_ff, cidx_in;
   logic [VALUE_BITS-1:0] wblk_ff, wblk_in, hunit_ff, hunit_in;
   logic [VALUE_BITS-1:0] crop_ff [4];
   logic [VALUE_BITS-1:0] crop_in [4];

   logic req_fire, bit_en, push_go;
   logic [VALUE_BITS-1:0] sp_units, sp_a, sp_b;
   logic sp_mult2, sp_clamp;
   logic [SIZE_BITS-1:0] sp_value;

   assign bit_en = (seq_ff == SEQ_BITS);
   assign push_go = (seq_ff == SEQ_PUSH) && !rsp_valid_ff;
   assign req_tready = (seq_ff == SEQ_IDLE) ||
                       (bit_en && bitcnt_ff == 3'd7 && !last_ff);
   assign req_fire = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   always_comb begin
      sp_units = wblk_ff;
      sp_mult2 = 1'b0;
      sp_a = crop_ff[0];
      sp_b = crop_ff[1];
      if (seq_ff == SEQ_SIZE_H) begin
         sp_units = hunit_ff;
         sp_mult2 = !fonly_ff;
         sp_a = crop_ff[2];
         sp_b = crop_ff[3];
      end
   end

   h264sps_span #(
      .VALUE_BITS(VALUE_BITS),
      .SIZE_BITS(SIZE_BITS)
   ) u_span (
      .units(sp_units),
      .mult2(sp_mult2),
      .off_a(sp_a),
      .off_b(sp_b),
      .size_value(sp_value),
      .size_clamped(sp_clamp)
   );

   always_comb begin
      seq_in = seq_ff;
      bitcnt_in = bitcnt_ff;
      shift_in = shift_ff;
      last_in = last_ff;
      wres_in = wres_ff;
      hres_in = hres_ff;
      clamp_in = clamp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      case (seq_ff)
         SEQ_IDLE: ;
         SEQ_BITS: begin
            shift_in = {shift_ff[6:0], 1'b0};
            bitcnt_in = bitcnt_ff + 3'd1;
            if (bitcnt_ff == 3'd7) seq_in = last_ff ? SEQ_SIZE_W : SEQ_IDLE;
         end
         SEQ_SIZE_W: begin
            wres_in = sp_value;
            clamp_in = sp_clamp;
            seq_in = SEQ_SIZE_H;
         end
         SEQ_SIZE_H: begin
            hres_in = sp_value;
            clamp_in = clamp_ff | sp_clamp;
            seq_in = SEQ_PUSH;
         end
         SEQ_PUSH: begin
            if (push_go) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = RSP_W'({step_ff != STEP_DONE, clamp_ff, hres_ff, wres_ff});
               seq_in = SEQ_IDLE;
            end
         end
         default: seq_in = SEQ_IDLE;
      endcase
      if (req_fire) begin
         shift_in = req_tdata;
         last_in = req_tlast;
         bitcnt_in = 3'd0;
         seq_in = SEQ_BITS;
      end
   end

   always_comb begin
      step_type nxt;
      logic fin;
      logic b;
      logic [VALUE_BITS-1:0] v;
      logic [VALUE_BITS-1:0] lm1;
      logic [7:0] dl;
      logic [7:0] ns;
      logic [6:0] cinc;
      logic [3:0] linc;
      step_in = step_ff;
      zrun_in = zrun_ff;
      left_in = left_ff;
      fval_in = fval_ff;
      loop_in = loop_ff;
      profile_in = profile_ff;
      lscale_in = lscale_ff;
      c444_in = c444_ff;
      fonly_in = fonly_ff;
      lidx_in = lidx_ff;
      cidx_in = cidx_ff;
      wblk_in = wblk_ff;
      hunit_in = hunit_ff;
      crop_in = crop_ff;
      nxt = step_ff;
      fin = 1'b0;
      b = shift_ff[7];
      v = '0;
      lm1 = loop_ff - VALUE_BITS'(1);
      cinc = cidx_ff + 7'd1;
      linc = lidx_ff + 4'd1;
      if (bit_en && step_ff != STEP_DONE) begin
         if (step_bits(step_ff) != 6'd0) begin
            fval_in = {fval_ff[VALUE_BITS-2:0], b};
            left_in = left_ff - 6'd1;
            if (left_ff == 6'd1) begin
               fin = 1'b1;
               v = fval_in;
            end
         end else if (fval_ff == '0) begin
            if (!b) begin
               if (zrun_ff < RUN_MAX) zrun_in = zrun_ff + 6'd1;
            end else begin
               fval_in = VALUE_BITS'(1);
               left_in = zrun_ff;
               if (zrun_ff == 6'd0) fin = 1'b1;
            end
         end else begin
            // codeword saturates at all ones
            fval_in = (fval_ff >= VALUE_TOP) ? '1 : {fval_ff[VALUE_BITS-2:0], b};
            left_in = left_ff - 6'd1;
            if (left_ff == 6'd1) begin
               fin = 1'b1;
               v = fval_in - VALUE_BITS'(1);
            end
         end
      end
      dl = v[0] ? (v[8:1] + 8'd1) : (8'd0 - v[8:1]);
      ns = lscale_ff + dl;
      if (fin) begin
         case (step_ff)
            STEP_HDR: nxt = STEP_PROFILE;
            STEP_PROFILE: begin
               profile_in = v[7:0];
               nxt = STEP_CONSTR;
            end
            STEP_CONSTR: nxt = STEP_SPSID;
            STEP_SPSID: nxt = high_profile(profile_ff) ? STEP_CHROMA : STEP_FRAMENUM;
            STEP_CHROMA: begin
               c444_in = (v == VALUE_BITS'(3));
               nxt = c444_in ? STEP_SEPPLANE : STEP_DEPTHL;
            end
            STEP_SEPPLANE: nxt = STEP_DEPTHL;
            STEP_DEPTHL: nxt = STEP_DEPTHC;
            STEP_DEPTHC: nxt = STEP_BYPASS;
            STEP_BYPASS: nxt = STEP_MATRIX;
            STEP_MATRIX: begin
               lidx_in = 4'd0;
               nxt = v[0] ? STEP_LISTFLAG : STEP_FRAMENUM;
            end
            STEP_LISTFLAG: begin
               if (v[0]) begin
                  lscale_in = SCALE_INIT;
                  cidx_in = 7'd0;
                  nxt = STEP_DELTA;
               end else begin
                  lidx_in = linc;
                  nxt = (linc < (c444_ff ? LISTS_444 : LISTS_STD)) ?
                        STEP_LISTFLAG : STEP_FRAMENUM;
               end
            end
            STEP_DELTA: begin
               if (ns != 8'd0) lscale_in = ns;
               cidx_in = cinc;
               if (ns != 8'd0 && cinc < ((lidx_ff < SMALL_LISTS) ? 7'd16 : 7'd64)) begin
                  nxt = STEP_DELTA;
               end else begin
                  lidx_in = linc;
                  nxt = (linc < (c444_ff ? LISTS_444 : LISTS_STD)) ?
                        STEP_LISTFLAG : STEP_FRAMENUM;
               end
            end
            STEP_FRAMENUM: nxt = STEP_POCTYPE;
            STEP_POCTYPE: begin
               if (v == '0) nxt = STEP_POCLSB;
               else if (v == VALUE_BITS'(1)) nxt = STEP_ALWAYS0;
               else nxt = STEP_NUMREF;
            end
            STEP_POCLSB: nxt = STEP_NUMREF;
            STEP_ALWAYS0: nxt = STEP_NONREF;
            STEP_NONREF: nxt = STEP_TOPBOT;
            STEP_TOPBOT: nxt = STEP_CYCLE;
            STEP_CYCLE: begin
               loop_in = v;
               nxt = (v == '0) ? STEP_NUMREF : STEP_REFOFF;
            end
            STEP_REFOFF: begin
               loop_in = lm1;
               nxt = (lm1 == '0) ? STEP_NUMREF : STEP_REFOFF;
            end
            STEP_NUMREF: nxt = STEP_GAPS;
            STEP_GAPS: nxt = STEP_WIDTH;
            STEP_WIDTH: begin
               wblk_in = v;
               nxt = STEP_HEIGHT;
            end
            STEP_HEIGHT: begin
               hunit_in = v;
               nxt = STEP_FRAMEONLY;
            end
            STEP_FRAMEONLY: begin
               fonly_in = v[0];
               nxt = v[0] ? STEP_DIRECT : STEP_MBAFF;
            end
            STEP_MBAFF: nxt = STEP_DIRECT;
            STEP_DIRECT: nxt = STEP_CROPFLAG;
            STEP_CROPFLAG: begin
               lidx_in = 4'd0;
               nxt = v[0] ? STEP_CROP : STEP_DONE;
            end
            STEP_CROP: begin
               crop_in[lidx_ff[1:0]] = v;
               lidx_in = linc;
               nxt = (linc >= CROP_COUNT) ? STEP_DONE : STEP_CROP;
            end
            default: nxt = STEP_DONE;
         endcase
         step_in = nxt;
         zrun_in = '0;
         fval_in = '0;
         left_in = step_bits(nxt);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= SEQ_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff <= seq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      bitcnt_ff <= bitcnt_in;
      shift_ff <= shift_in;
      last_ff <= last_in;
      wres_ff <= wres_in;
      hres_ff <= hres_in;
      clamp_ff <= clamp_in;
      rsp_data_ff <= rsp_data_in;
   end

   // walker returns to the header after each result
   always_ff @(posedge clock) begin
      if (reset || push_go) begin
         step_ff <= STEP_HDR;
         zrun_ff <= '0;
         left_ff <= step_bits(STEP_HDR);
         fval_ff <= '0;
         loop_ff <= '0;
         profile_ff <= '0;
         lscale_ff <= SCALE_INIT;
         c444_ff <= 1'b0;
         fonly_ff <= 1'b0;
         lidx_ff <= '0;
         cidx_ff <= '0;
         wblk_ff <= '0;
         hunit_ff <= '0;
         for (int i = 0; i < 4; i++) crop_ff[i] <= '0;
      end else begin
         step_ff <= step_in;
         zrun_ff <= zrun_in;
         left_ff <= left_in;
         fval_ff <= fval_in;
         loop_ff <= loop_in;
         profile_ff <= profile_in;
         lscale_ff <= lscale_in;
         c444_ff <= c444_in;
         fonly_ff <= fonly_in;
         lidx_ff <= lidx_in;
         cidx_ff <= cidx_in;
         wblk_ff <= wblk_in;
         hunit_ff <= hunit_in;
         crop_ff <= crop_in;
      end
   end

   a_rsp_from_push: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(seq_ff == SEQ_PUSH))
      else $error("result raised outside push");

   a_last_to_size: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tlast |-> ##9 (seq_ff == SEQ_SIZE_W))
      else $error("final byte did not reach size unit after eight bits");

   a_walker_cleared: assert property (@(posedge clock) disable iff (reset)
      push_go |=> (step_ff == STEP_HDR && fval_ff == '0))
      else $error("walker not cleared after result");

   a_no_bits_when_done: assert property (@(posedge clock) disable iff (reset)
      step_ff == STEP_DONE && !push_go |=> step_ff == STEP_DONE)
      else $error("walker left done state");
endmodule
